### hdl/fsnf_pkg.sv
// ============================================================================
// fsnf_pkg - shared definitions for the format string number formatter
// Count width, character codes, sequencer and converter types, digit table.
// ============================================================================
package fsnf_pkg;

    // Width of the room and written counters
    localparam int COUNT_WIDTH   = 16;
    // Width of the written_count port
    localparam int OUT_CNT_WIDTH = 16;

    localparam int ARG_WIDTH     = 64;
    localparam int HALF_WIDTH    = 32;
    localparam int DEC_DIGITS    = 20;
    localparam int HEX_DIGITS    = 16;
    localparam int BCD_WIDTH     = DEC_DIGITS * 4;
    localparam int BIT_CNT_WIDTH = $clog2(ARG_WIDTH + 1);
    localparam int DIG_CNT_WIDTH = $clog2(DEC_DIGITS + 1);

    localparam logic [7:0] CH_PCT   = 8'h25;  // '%'
    localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_C     = 8'h63;  // 'c'
    localparam logic [7:0] CH_D     = 8'h64;  // 'd'
    localparam logic [7:0] CH_L     = 8'h6C;  // 'l'
    localparam logic [7:0] CH_P     = 8'h70;  // 'p'
    localparam logic [7:0] CH_U     = 8'h75;  // 'u'
    localparam logic [7:0] CH_X     = 8'h78;  // 'x'

    // "0123456789abcdef"
    localparam logic [7:0] HEX_TABLE [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };

    typedef enum logic [1:0] {
        MODE_COPY,
        MODE_PCT,
        MODE_LONG
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHAR,
        ST_XCHAR,
        ST_DIGITS,
        ST_COUNT
    } seq_state_t;

    typedef enum logic [1:0] {
        CV_IDLE,
        CV_SHIFT,
        CV_DIGITS
    } conv_state_t;

    typedef struct packed {
        logic                 load;
        logic                 hex;
        logic                 wide;
        logic [ARG_WIDTH-1:0] value;
        logic                 take;
    } conv_cmd_t;

    typedef struct packed {
        logic       digit_valid;
        logic [3:0] digit;
        logic       final_digit;
    } conv_stat_t;

    typedef struct packed {
        logic        start;
        logic [15:0] cap;
        logic        push;
        logic        is_char;
        logic [7:0]  ch;
        logic        final_char;
    } emit_cmd_t;

    typedef struct packed {
        logic slot_free;
        logic room_zero;
    } emit_stat_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        return HEX_TABLE[d];
    endfunction

endpackage

### hdl/format_string_number_formatter_top.sv
// ============================================================================
// format_string_number_formatter_top - printf subset formatter
// Parses format bytes, converts arguments and emits one character per beat.
// ============================================================================
// One format byte is taken per input beat, together with its argument word.
// Plain bytes are copied; '%' opens a conversion, an optional 'l' selects the
// full 64-bit argument, and c, d, u, x, p and %% are converted. Any other
// specifier emits nothing. Each written character leaves as one output beat
// with the running count; the last beat of an input is flagged by last. A
// beat with is_start clears the parser and the count and loads the room from
// capacity (minus one for the terminator); a beat with is_end returns one
// count-only beat. Characters past the room are dropped. Items are handled
// one at a time. A decimal conversion runs a bit-serial shift-add-3
// conversion in the converter over the low 32 bits (plain) or all 64 bits
// (with 'l'), then walks out the 20 digit positions; x walks out the 16
// hex digit positions, and p does the same after its "0x" prefix. In both
// cases leading zeros are skipped. The converter takes a single bit per
// cycle, and a stalled output holds the digit walk beat for beat.
// ============================================================================
module format_string_number_formatter_top
    import fsnf_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [7:0]               fmt_char,
    input  logic [ARG_WIDTH-1:0]     arg_value,
    input  logic                     is_start,
    input  logic                     is_end,
    input  logic [15:0]              capacity,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [7:0]               out_char,
    output logic                     char_valid,
    output logic [OUT_CNT_WIDTH-1:0] written_count,
    output logic                     last
);

    seq_state_t state_reg, state_next;
    mode_t      mode_reg, mode_next;
    logic [7:0] char_reg, char_next;
    logic       xpend_reg, xpend_next;   // 'x' of the p prefix still to come
    logic       num_reg, num_next;       // digits follow the pending character

    logic                 accept;
    mode_t                cur_mode;
    logic                 wide;
    logic                 neg;
    logic [ARG_WIDTH-1:0] arg_sel;
    logic [ARG_WIDTH-1:0] arg_mag;
    logic [HALF_WIDTH-1:0] narrow_neg;

    // decode of the accepted beat
    seq_state_t           dec_state;
    mode_t                dec_mode;
    logic [7:0]           dec_char;
    logic                 dec_xpend;
    logic                 dec_num;
    logic                 dec_load;
    logic                 dec_hex;
    logic [ARG_WIDTH-1:0] dec_value;

    conv_cmd_t  conv_cmd;
    conv_stat_t conv_stat;
    emit_cmd_t  emit_cmd;
    emit_stat_t emit_stat;

    assign accept   = in_valid && in_ready;
    assign cur_mode = is_start ? MODE_COPY : mode_reg;
    assign wide     = (cur_mode == MODE_LONG);

    // without 'l' only the low word counts; d takes the magnitude
    assign arg_sel    = wide ? arg_value
                             : {{(ARG_WIDTH - HALF_WIDTH){1'b0}}, arg_value[HALF_WIDTH-1:0]};
    assign neg        = wide ? arg_value[ARG_WIDTH-1] : arg_value[HALF_WIDTH-1];
    assign narrow_neg = ~arg_value[HALF_WIDTH-1:0] + HALF_WIDTH'(1);
    assign arg_mag    = wide ? (~arg_value + ARG_WIDTH'(1))
                             : {{(ARG_WIDTH - HALF_WIDTH){1'b0}}, narrow_neg};

    always_comb
    begin
        dec_state = ST_IDLE;
        dec_mode  = cur_mode;
        dec_char  = fmt_char;
        dec_xpend = 1'b0;
        dec_num   = 1'b0;
        dec_load  = 1'b0;
        dec_hex   = 1'b0;
        dec_value = arg_sel;
        if (is_end)
        begin
            dec_mode  = MODE_COPY;
            dec_state = ST_COUNT;
        end
        else if (cur_mode == MODE_COPY)
        begin
            if (fmt_char == CH_PCT)
                dec_mode = MODE_PCT;
            else
                dec_state = ST_CHAR;
        end
        else if (cur_mode == MODE_PCT && fmt_char == CH_L)
        begin
            dec_mode = MODE_LONG;
        end
        else
        begin
            dec_mode = MODE_COPY;
            case (fmt_char)
                CH_C:
                begin
                    dec_char  = arg_value[7:0];
                    dec_state = ST_CHAR;
                end
                CH_D:
                begin
                    dec_load = 1'b1;
                    if (neg)
                    begin
                        dec_value = arg_mag;
                        dec_char  = CH_MINUS;
                        dec_num   = 1'b1;
                        dec_state = ST_CHAR;
                    end
                    else
                    begin
                        dec_state = ST_DIGITS;
                    end
                end
                CH_U:
                begin
                    dec_load  = 1'b1;
                    dec_state = ST_DIGITS;
                end
                CH_X:
                begin
                    dec_load  = 1'b1;
                    dec_hex   = 1'b1;
                    dec_state = ST_DIGITS;
                end
                CH_P:
                begin
                    // p always takes the whole argument word
                    dec_load  = 1'b1;
                    dec_hex   = 1'b1;
                    dec_value = arg_value;
                    dec_char  = CH_ZERO;
                    dec_xpend = 1'b1;
                    dec_num   = 1'b1;
                    dec_state = ST_CHAR;
                end
                CH_PCT:
                begin
                    dec_state = ST_CHAR;
                end
                default: ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = dec_state;
            end
            ST_CHAR:
            begin
                if (emit_stat.room_zero)
                    state_next = ST_IDLE;
                else if (emit_stat.slot_free)
                begin
                    if (xpend_reg)
                        state_next = ST_XCHAR;
                    else if (num_reg)
                        state_next = ST_DIGITS;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_XCHAR:
            begin
                if (emit_stat.room_zero)
                    state_next = ST_IDLE;
                else if (emit_stat.slot_free)
                    state_next = ST_DIGITS;
            end
            ST_DIGITS:
            begin
                // drop the rest of the number once the room runs out
                if (emit_stat.room_zero)
                    state_next = ST_IDLE;
                else if (emit_stat.slot_free && conv_stat.digit_valid
                         && conv_stat.final_digit)
                    state_next = ST_IDLE;
            end
            ST_COUNT:
            begin
                if (emit_stat.slot_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs and commands
    always_comb
    begin
        in_ready   = (state_reg == ST_IDLE);
        mode_next  = mode_reg;
        char_next  = char_reg;
        xpend_next = xpend_reg;
        num_next   = num_reg;

        conv_cmd.load  = 1'b0;
        conv_cmd.hex   = dec_hex;
        conv_cmd.wide  = wide;
        conv_cmd.value = dec_value;
        conv_cmd.take  = 1'b0;

        emit_cmd.start      = 1'b0;
        emit_cmd.cap        = capacity;
        emit_cmd.push       = 1'b0;
        emit_cmd.is_char    = 1'b1;
        emit_cmd.ch         = char_reg;
        emit_cmd.final_char = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    mode_next      = dec_mode;
                    char_next      = dec_char;
                    xpend_next     = dec_xpend;
                    num_next       = dec_num;
                    conv_cmd.load  = dec_load;
                    emit_cmd.start = is_start;
                end
            end
            ST_CHAR:
            begin
                emit_cmd.push       = emit_stat.slot_free && !emit_stat.room_zero;
                emit_cmd.final_char = !num_reg;
            end
            ST_XCHAR:
            begin
                emit_cmd.push = emit_stat.slot_free && !emit_stat.room_zero;
                emit_cmd.ch   = CH_X;
            end
            ST_DIGITS:
            begin
                emit_cmd.push       = emit_stat.slot_free && !emit_stat.room_zero
                                      && conv_stat.digit_valid;
                emit_cmd.ch         = digit_char(conv_stat.digit);
                emit_cmd.final_char = conv_stat.final_digit;
                conv_cmd.take       = emit_cmd.push;
            end
            ST_COUNT:
            begin
                emit_cmd.push    = emit_stat.slot_free;
                emit_cmd.is_char = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mode_reg  <= MODE_COPY;
            xpend_reg <= 1'b0;
            num_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            xpend_reg <= xpend_next;
            num_reg   <= num_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
    end

    fsnf_conv u_conv (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (conv_cmd),
        .stat  (conv_stat)
    );

    fsnf_emit u_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (emit_cmd),
        .stat          (emit_stat),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_char      (out_char),
        .char_valid    (char_valid),
        .written_count (written_count),
        .last          (last)
    );

endmodule

### hdl/fsnf_conv.sv
// ============================================================================
// fsnf_conv - bit-serial binary to digit converter
// Shift-add-3 decimal conversion one bit per cycle (hex skips it), then digits
// leave one nibble per cycle from the top while taken, leading zeros skipped.
// ============================================================================
module fsnf_conv
    import fsnf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  conv_cmd_t  cmd,
    output conv_stat_t stat
);

    conv_state_t              state_reg, state_next;
    logic [ARG_WIDTH-1:0]     bin_reg, bin_next;
    logic [BCD_WIDTH-1:0]     bcd_reg, bcd_next;
    logic [BCD_WIDTH-1:0]     bcd_adj;
    logic [BIT_CNT_WIDTH-1:0] bit_cnt_reg, bit_cnt_next;
    logic [DIG_CNT_WIDTH-1:0] dig_cnt_reg, dig_cnt_next;
    logic                     seen_reg, seen_next;
    logic [3:0]               top_digit;
    logic                     final_digit;
    logic                     lead_zero;

    assign top_digit   = bcd_reg[BCD_WIDTH-1 -: 4];
    assign final_digit = (dig_cnt_reg == DIG_CNT_WIDTH'(1));
    assign lead_zero   = (top_digit == 4'd0) && !seen_reg && !final_digit;

    // add 3 to every digit of five or more before the shift
    always_comb
    begin
        for (int i = 0; i < DEC_DIGITS; i++)
        begin
            if (bcd_reg[i*4 +: 4] >= 4'd5)
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            else
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CV_IDLE:   state_next = CV_IDLE;
            CV_SHIFT:
            begin
                if (bit_cnt_reg == BIT_CNT_WIDTH'(1))
                    state_next = CV_DIGITS;
            end
            CV_DIGITS:
            begin
                if (cmd.take && final_digit)
                    state_next = CV_IDLE;
            end
            default:   state_next = CV_IDLE;
        endcase
        if (cmd.load)
            state_next = cmd.hex ? CV_DIGITS : CV_SHIFT;
    end

    always_comb
    begin
        bin_next     = bin_reg;
        bcd_next     = bcd_reg;
        bit_cnt_next = bit_cnt_reg;
        dig_cnt_next = dig_cnt_reg;
        seen_next    = seen_reg;
        if (cmd.load)
        begin
            seen_next = 1'b0;
            if (cmd.hex)
            begin
                bcd_next     = {cmd.value, {(BCD_WIDTH - ARG_WIDTH){1'b0}}};
                dig_cnt_next = DIG_CNT_WIDTH'(HEX_DIGITS);
            end
            else
            begin
                bcd_next     = '0;
                dig_cnt_next = DIG_CNT_WIDTH'(DEC_DIGITS);
                if (cmd.wide)
                begin
                    bin_next     = cmd.value;
                    bit_cnt_next = BIT_CNT_WIDTH'(ARG_WIDTH);
                end
                else
                begin
                    bin_next     = {cmd.value[HALF_WIDTH-1:0], {(ARG_WIDTH - HALF_WIDTH){1'b0}}};
                    bit_cnt_next = BIT_CNT_WIDTH'(HALF_WIDTH);
                end
            end
        end
        else
        begin
            case (state_reg)
                CV_SHIFT:
                begin
                    bcd_next     = {bcd_adj[BCD_WIDTH-2:0], bin_reg[ARG_WIDTH-1]};
                    bin_next     = {bin_reg[ARG_WIDTH-2:0], 1'b0};
                    bit_cnt_next = bit_cnt_reg - BIT_CNT_WIDTH'(1);
                end
                CV_DIGITS:
                begin
                    if (cmd.take || lead_zero)
                    begin
                        bcd_next     = {bcd_reg[BCD_WIDTH-5:0], 4'd0};
                        dig_cnt_next = dig_cnt_reg - DIG_CNT_WIDTH'(1);
                    end
                    if (cmd.take)
                        seen_next = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        stat.digit_valid = (state_reg == CV_DIGITS) && !lead_zero;
        stat.digit       = top_digit;
        stat.final_digit = final_digit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= CV_IDLE;
            bit_cnt_reg <= '0;
            dig_cnt_reg <= '0;
            seen_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
            dig_cnt_reg <= dig_cnt_next;
            seen_reg    <= seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

endmodule

### hdl/fsnf_emit.sv
// ============================================================================
// fsnf_emit - output register with room and written counters
// Holds one result beat, counts down room, counts up written characters.
// ============================================================================
module fsnf_emit
    import fsnf_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  emit_cmd_t                cmd,
    output emit_stat_t               stat,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [7:0]               out_char,
    output logic                     char_valid,
    output logic [OUT_CNT_WIDTH-1:0] written_count,
    output logic                     last
);

    logic [COUNT_WIDTH-1:0]               room_reg, room_next;
    logic [COUNT_WIDTH-1:0]               total_reg, total_next;
    logic [COUNT_WIDTH-1:0]               total_inc;
    logic [COUNT_WIDTH+OUT_CNT_WIDTH-1:0] total_inc_ext;
    logic [COUNT_WIDTH+OUT_CNT_WIDTH-1:0] total_ext;
    logic [15:0]                          cap_dec;
    logic [COUNT_WIDTH+15:0]              cap_ext;
    logic [COUNT_WIDTH+15:0]              cnt_max_ext;
    logic [COUNT_WIDTH-1:0]               room_load;
    logic                                 valid_reg, valid_next;
    logic [7:0]                           char_reg;
    logic                                 cvalid_reg;
    logic [OUT_CNT_WIDTH-1:0]             count_reg;
    logic                                 last_reg;

    assign total_inc     = total_reg + COUNT_WIDTH'(1);
    assign total_inc_ext = {{OUT_CNT_WIDTH{1'b0}}, total_inc};
    assign total_ext     = {{OUT_CNT_WIDTH{1'b0}}, total_reg};

    // one place is kept for the terminator; saturate at the counter range
    assign cap_dec     = (cmd.cap == 16'd0) ? 16'd0 : cmd.cap - 16'd1;
    assign cap_ext     = {{COUNT_WIDTH{1'b0}}, cap_dec};
    assign cnt_max_ext = {16'd0, {COUNT_WIDTH{1'b1}}};
    assign room_load   = (cap_ext > cnt_max_ext) ? {COUNT_WIDTH{1'b1}}
                                                 : cap_ext[COUNT_WIDTH-1:0];

    assign stat.slot_free = !valid_reg || out_ready;
    assign stat.room_zero = (room_reg == '0);

    always_comb
    begin
        room_next  = room_reg;
        total_next = total_reg;
        valid_next = valid_reg;
        if (valid_reg && out_ready)
            valid_next = 1'b0;
        if (cmd.start)
        begin
            room_next  = room_load;
            total_next = '0;
        end
        else if (cmd.push)
        begin
            valid_next = 1'b1;
            if (cmd.is_char)
            begin
                room_next  = room_reg - COUNT_WIDTH'(1);
                total_next = total_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            room_reg  <= '0;
            total_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            room_reg  <= room_next;
            total_reg <= total_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push && !cmd.start)
        begin
            if (cmd.is_char)
            begin
                char_reg   <= cmd.ch;
                cvalid_reg <= 1'b1;
                count_reg  <= total_inc_ext[OUT_CNT_WIDTH-1:0];
                last_reg   <= cmd.final_char || (room_reg == COUNT_WIDTH'(1));
            end
            else
            begin
                char_reg   <= 8'd0;
                cvalid_reg <= 1'b0;
                count_reg  <= total_ext[OUT_CNT_WIDTH-1:0];
                last_reg   <= 1'b1;
            end
        end
    end

    assign out_valid     = valid_reg;
    assign out_char      = char_reg;
    assign char_valid    = cvalid_reg;
    assign written_count = count_reg;
    assign last          = last_reg;

endmodule

### hdl/fsnf_checker.sv
// ============================================================================
// fsnf_checker - port level checks for the formatter
// Watches the top level ports and flags beats that break its rules.
// ============================================================================
module fsnf_checker
    import fsnf_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic                     is_end,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic [7:0]               out_char,
    input logic                     char_valid,
    input logic [OUT_CNT_WIDTH-1:0] written_count,
    input logic                     last
);

    // a count-only beat closes its input and carries no character
    a_count_beat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !char_valid |-> last && out_char == 8'd0)
        else $error("count-only beat without last or with a character");

    // a written character always bumps the count above zero
    a_char_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && char_valid |-> written_count != '0)
        else $error("character beat with zero count");

    // an end beat always yields a result, so input must hold off
    a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && is_end |=> !in_ready)
        else $error("input taken again before the count beat");

    // hold a stalled output beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_char)
            && $stable(char_valid) && $stable(written_count) && $stable(last))
        else $error("stalled output beat changed");

endmodule

bind format_string_number_formatter_top fsnf_checker u_fsnf_checker (.*);

### sim/format_string_number_formatter_top_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// format_string_number_formatter_top_tb - self-checking bench for the formatter
// Drives format strings with argument words, predicts every written character
// and count beat, and compares the output stream field by field.
// ============================================================================
module format_string_number_formatter_top_tb;
    import fsnf_pkg::*;

    // Specifier codes not named in the package
    localparam logic [7:0] CH_S = 8'h73;  // 's', not supported, emits nothing
    localparam logic [7:0] CH_Q = 8'h71;  // 'q', unknown specifier

    // Cycles without any accepted beat before the run is declared hung
    localparam int HANG_LIMIT = 5000;
    // Cycles to let pass after the last expected beat
    localparam int TAIL_CYCLES = 200;
    // Input beats per random phase
    localparam int PHASE_BEATS = 40;

    typedef struct {
        logic [7:0]               out_char;
        logic                     char_valid;
        logic [OUT_CNT_WIDTH-1:0] written_count;
        logic                     last;
    } fmt_beat_t;

    // ------------------------------------------------------------------------
    // Formatter predictor and store of pending output beats
    // ------------------------------------------------------------------------
    class fmt_scoreboard;
        fmt_beat_t              pending_q[$];
        fmt_beat_t              step_q[$];
        mode_t                  mode;
        logic [COUNT_WIDTH-1:0] room;
        logic [COUNT_WIDTH-1:0] total;
        int                     failures;

        function new();
            mode     = MODE_COPY;
            room     = '0;
            total    = '0;
            failures = 0;
        endfunction

        function int pending();
            return pending_q.size();
        endfunction

        // Write one character if there is room; at most 20 per input beat
        function void put_char(logic [7:0] ch);
            fmt_beat_t b;
            if (room == 0 || step_q.size() >= 20)
                return;
            room            = room - 1'b1;
            total           = total + 1'b1;
            b.out_char      = ch;
            b.char_valid    = 1'b1;
            b.written_count = total[OUT_CNT_WIDTH-1:0];
            b.last          = 1'b0;
            step_q.push_back(b);
        endfunction

        function void put_number(logic [63:0] v, bit hex);
            logic [7:0]  digits[$];
            logic [63:0] base;
            base = hex ? 64'd16 : 64'd10;
            if (v == 0)
                digits.push_front(CH_ZERO);
            while (v != 0)
            begin
                digits.push_front(HEX_TABLE[4'(v % base)]);
                v = v / base;
            end
            foreach (digits[i])
                put_char(digits[i]);
        endfunction

        function void convert(logic [7:0] spec, logic [63:0] arg, bit wide);
            logic [63:0] v;
            bit          neg;
            v = wide ? arg : {32'd0, arg[31:0]};
            case (spec)
                CH_C: put_char(arg[7:0]);
                CH_D:
                begin
                    neg = wide ? v[63] : v[31];
                    if (neg)
                    begin
                        v = wide ? (64'd0 - v) : (64'h1_0000_0000 - v);
                        put_char(CH_MINUS);
                    end
                    put_number(v, 1'b0);
                end
                CH_U: put_number(v, 1'b0);
                CH_X: put_number(v, 1'b1);
                CH_P:
                begin
                    put_char(CH_ZERO);
                    put_char(CH_X);
                    put_number(arg, 1'b1);
                end
                CH_PCT: put_char(CH_PCT);
                default: ;
            endcase
        endfunction

        // Advance the model by one accepted input beat, queue what it writes
        function void note_input(logic [7:0] ch, logic [63:0] arg, logic st, logic en,
                                 logic [15:0] cap);
            fmt_beat_t b;
            int        r;
            step_q.delete();
            if (st)
            begin
                r = (cap == 0) ? 0 : int'(cap) - 1;
                if (r > (2 ** COUNT_WIDTH) - 1)
                    r = (2 ** COUNT_WIDTH) - 1;
                mode  = MODE_COPY;
                total = '0;
                room  = COUNT_WIDTH'(r);
            end
            if (en)
            begin
                mode            = MODE_COPY;
                b.out_char      = 8'd0;
                b.char_valid    = 1'b0;
                b.written_count = total[OUT_CNT_WIDTH-1:0];
                b.last          = 1'b1;
                pending_q.push_back(b);
                return;
            end
            if (mode == MODE_COPY)
            begin
                if (ch == CH_PCT)
                    mode = MODE_PCT;
                else
                    put_char(ch);
            end
            else if (mode == MODE_PCT && ch == CH_L)
                mode = MODE_LONG;
            else
            begin
                convert(ch, arg, mode == MODE_LONG);
                mode = MODE_COPY;
            end
            if (step_q.size() > 0)
                step_q[step_q.size()-1].last = 1'b1;
            foreach (step_q[i])
                pending_q.push_back(step_q[i]);
        endfunction

        function void check_result(fmt_beat_t got);
            fmt_beat_t want;
            if (pending_q.size() == 0)
            begin
                if (failures < 10)
                    $display("unexpected output beat: char %h valid %b count %0d last %b",
                             got.out_char, got.char_valid, got.written_count, got.last);
                failures++;
                return;
            end
            want = pending_q.pop_front();
            if (got.out_char !== want.out_char || got.char_valid !== want.char_valid ||
                got.written_count !== want.written_count || got.last !== want.last)
            begin
                if (failures < 10)
                    $display("mismatch: expected char %h valid %b count %0d last %b, %s",
                             want.out_char, want.char_valid, want.written_count, want.last,
                             $sformatf("got char %h valid %b count %0d last %b",
                                       got.out_char, got.char_valid, got.written_count,
                                       got.last));
                failures++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block ports; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [7:0]               fmt_char = 8'd0;
    logic [ARG_WIDTH-1:0]     arg_value = '0;
    logic                     is_start = 1'b0;
    logic                     is_end = 1'b0;
    logic [15:0]              capacity = 16'd0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [7:0]               out_char;
    logic                     char_valid;
    logic [OUT_CNT_WIDTH-1:0] written_count;
    logic                     last;

    fmt_scoreboard sb;
    int            send_idle = 0;   // percent of cycles the sender holds off
    int            recv_stall = 0;  // percent of cycles the receiver stalls
    int            beats_sent = 0;
    int            idle_cycles = 0;

    format_string_number_formatter_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .fmt_char      (fmt_char),
        .arg_value     (arg_value),
        .is_start      (is_start),
        .is_end        (is_end),
        .capacity      (capacity),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_char      (out_char),
        .char_valid    (char_valid),
        .written_count (written_count),
        .last          (last)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Receiver: stall at random per the current phase
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall);

    // Monitor both channels at the clock edge; feed the scoreboard and count
    // cycles in which nothing moves
    always @(posedge clk)
    begin
        fmt_beat_t got;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_input(fmt_char, arg_value, is_start, is_end, capacity);
            if (out_valid && out_ready)
            begin
                got.out_char      = out_char;
                got.char_valid    = char_valid;
                got.written_count = written_count;
                got.last          = last;
                sb.check_result(got);
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Watchdog: end the run if the channels stay quiet too long
    initial
    begin
        while (idle_cycles < HANG_LIMIT)
            @(posedge clk);
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Driving tasks
    // ------------------------------------------------------------------------

    // Present one input beat and hold it until accepted
    task automatic send_beat(input logic [7:0] ch, input logic [63:0] arg,
                             input logic st, input logic en, input logic [15:0] cap);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        fmt_char  <= ch;
        arg_value <= arg;
        is_start  <= st;
        is_end    <= en;
        capacity  <= cap;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        beats_sent++;
    endtask

    // Plain beat with random argument and ignored capacity bits
    task automatic send_char(input logic [7:0] ch);
        send_beat(ch, {$urandom, $urandom}, 1'b0, 1'b0, 16'($urandom));
    endtask

    // Drop valid and hold off until every expected beat has come back;
    // first wait for the clock so the monitor has noted the last accepted beat
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic [63:0] pick_arg();
        case ($urandom_range(7))
            0: return 64'd0;
            1: return '1;
            2: return 64'h8000_0000_0000_0000;
            3: return {$urandom, 32'h8000_0000};
            4: return 64'($urandom_range(1000));
            5: return {32'($urandom_range(3)), $urandom};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [15:0] pick_capacity();
        case ($urandom_range(9))
            0: return 16'd0;
            1: return 16'd1;
            2: return 16'($urandom_range(2, 8));
            3: return 16'hFFFF;
            4, 5: return 16'($urandom_range(9, 40));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_spec();
        logic [7:0] specs[6];
        specs = '{CH_C, CH_D, CH_U, CH_X, CH_P, CH_PCT};
        case ($urandom_range(9))
            0: return CH_L;
            1: return CH_S;
            2: return 8'($urandom);
            default: return specs[$urandom_range(5)];
        endcase
    endfunction

    // One format string: start beat, a mix of plain bytes and conversions,
    // end beat; now and then skip the start or the end, or break a conversion
    task automatic random_format();
        int         n_items;
        logic [7:0] ch;
        n_items = $urandom_range(1, 10);
        if ($urandom_range(9) != 0)
            send_beat(8'($urandom), pick_arg(), 1'b1, ($urandom_range(19) == 0),
                      pick_capacity());
        for (int i = 0; i < n_items; i++)
        begin
            if ($urandom_range(99) < 40)
            begin
                ch = 8'($urandom);
                if (ch == CH_PCT && $urandom_range(3) != 0)
                    ch = CH_ZERO;
                send_beat(ch, {$urandom, $urandom}, ($urandom_range(49) == 0), 1'b0,
                          pick_capacity());
            end
            else
            begin
                send_char(CH_PCT);
                if ($urandom_range(1) != 0)
                    send_char(CH_L);
                if ($urandom_range(29) == 0)
                    send_beat(8'($urandom), pick_arg(), 1'b0, 1'b1, 16'($urandom));
                else
                    send_beat(pick_spec(), pick_arg(), 1'b0, 1'b0, 16'($urandom));
            end
        end
        if ($urandom_range(9) != 0)
            send_beat(8'($urandom), {$urandom, $urandom}, 1'b0, 1'b1, 16'($urandom));
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int idle_tab[4];
        int stall_tab[4];
        int phase_end;
        idle_tab  = '{0, 52, 0, 37};
        stall_tab = '{0, 0, 52, 37};
        sb = new();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, no idling
        // Without a start the room is zero: nothing is written, count stays 0
        send_char(8'h41);
        send_beat(8'h41, 64'd0, 1'b0, 1'b1, 16'd0);
        // Zero capacity
        send_beat(8'h41, 64'd0, 1'b1, 1'b0, 16'd0);
        send_beat(8'h42, 64'd0, 1'b0, 1'b1, 16'd0);
        // Largest capacity; zero byte and top byte are copied as plain bytes
        send_beat(8'h00, '1, 1'b1, 1'b0, 16'hFFFF);
        send_char(8'hFF);
        // Most negative 32-bit value, upper half set and ignored
        send_char(CH_PCT);
        send_beat(CH_D, 64'hFFFF_FFFF_8000_0000, 1'b0, 1'b0, 16'd0);
        // Most negative 64-bit value
        send_char(CH_PCT);
        send_char(CH_L);
        send_beat(CH_D, 64'h8000_0000_0000_0000, 1'b0, 1'b0, 16'd0);
        // Largest unsigned, twenty digits
        send_char(CH_PCT);
        send_char(CH_L);
        send_beat(CH_U, '1, 1'b0, 1'b0, 16'd0);
        // Hex of zero
        send_char(CH_PCT);
        send_beat(CH_X, 64'hFFFF_FFFF_0000_0000, 1'b0, 1'b0, 16'd0);
        // Pointer uses all 64 bits without 'l'
        send_char(CH_PCT);
        send_beat(CH_P, '1, 1'b0, 1'b0, 16'd0);
        send_char(CH_PCT);
        send_char(CH_PCT);
        send_char(CH_PCT);
        send_beat(CH_C, 64'h0123_4567_89AB_CD41, 1'b0, 1'b0, 16'd0);
        // Dropped conversions: s, a second 'l', an unknown specifier
        send_char(CH_PCT);
        send_char(CH_S);
        send_char(CH_PCT);
        send_char(CH_L);
        send_char(CH_L);
        send_char(CH_PCT);
        send_char(CH_Q);
        // Dangling '%' at the end
        send_char(CH_PCT);
        send_beat(8'h00, 64'd0, 1'b0, 1'b1, 16'd0);
        // Buffer full: capacity 3 leaves room for two characters
        send_beat(8'h68, 64'd0, 1'b1, 1'b0, 16'd3);
        send_char(8'h69);
        send_char(8'h6A);
        send_beat(8'h00, 64'd0, 1'b0, 1'b1, 16'd0);
        drain();

        // Random phases with different idle and stall rates; drain between
        for (int p = 0; p < 4; p++)
        begin
            send_idle  = idle_tab[p];
            recv_stall = stall_tab[p];
            phase_end  = beats_sent + PHASE_BEATS;
            while (beats_sent < phase_end)
                random_format();
            drain();
        end

        recv_stall = 0;
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.failures == 0 && sb.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
